[rtl/rau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int NUM_W   = 32;
  localparam int DEN_W   = 31;
  localparam int ACT_W   = 4;
  localparam int Q_DEPTH = 2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD  = 4'd0,
    ACT_SUB  = 4'd1,
    ACT_MUL  = 4'd2,
    ACT_DIV  = 4'd3,
    ACT_CMP  = 4'd4,
    ACT_MOD  = 4'd5,
    ACT_NEG  = 4'd6,
    ACT_ABS  = 4'd7,
    ACT_SIGN = 4'd8,
    ACT_SQRT = 4'd9,
    ACT_MAX  = 4'd10,
    ACT_MIN  = 4'd11
  } action_e;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [NUM_W-1:0] a_num;
    logic [DEN_W-1:0] a_den;
    logic [NUM_W-1:0] b_num;
    logic [DEN_W-1:0] b_den;
    logic             den_err;
    logic             unknown;
  } item_t;

endpackage

[rtl/rational_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact rational ALU with gcd-reduced results.
// ----------------------------------------------------------------------------
// A transaction is taken when start_i is high and busy_o is low; up to two
// transactions wait in a queue while one executes. Each transaction gives one
// result, shown for a single cycle with done_o high; the receiver cannot stall
// it. How long an item takes depends on its action: unknown actions, bad
// denominators and zero operands skip most of the work, and the longest items
// are set by the binary gcd (one shift or subtract per cycle) and the 64-step
// restoring divider used twice per reduction; add and subtract need three
// reductions plus one gcd and two divides, while compare, max and min need two
// reductions plus the same gcd and two divides.
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [ACT_W-1:0] action_i,
  input  logic [NUM_W-1:0] a_num_i,
  input  logic [DEN_W-1:0] a_den_i,
  input  logic [NUM_W-1:0] b_num_i,
  input  logic [DEN_W-1:0] b_den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] res_num_o,
  output logic [DEN_W-1:0] res_den_o,
  output logic             less_o,
  output logic             equal_o,
  output logic             is_square_o,
  output logic [1:0]       status_o
);

  item_t in_item, head_item;
  logic  push, full, pop, empty;

  rau_front u_front (
    .start_i  (start_i),
    .full_i   (full),
    .busy_o   (busy_o),
    .action_i (action_i),
    .a_num_i  (a_num_i),
    .a_den_i  (a_den_i),
    .b_num_i  (b_num_i),
    .b_den_i  (b_den_i),
    .push_o   (push),
    .item_o   (in_item)
  );

  rau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (head_item)
  );

  rau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .done_o      (done_o),
    .res_num_o   (res_num_o),
    .res_den_o   (res_den_o),
    .less_o      (less_o),
    .equal_o     (equal_o),
    .is_square_o (is_square_o),
    .status_o    (status_o)
  );

endmodule

[rtl/rau_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_queue
// Short FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
module rau_queue import rau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  localparam int AW = $clog2(Q_DEPTH);

  item_t         mem_q [Q_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

[rtl/rau_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_front
// Accepts transactions and flags bad denominators and unknown actions.
// ----------------------------------------------------------------------------
module rau_front import rau_pkg::*; (
  input  logic             start_i,
  input  logic             full_i,
  output logic             busy_o,
  input  logic [ACT_W-1:0] action_i,
  input  logic [NUM_W-1:0] a_num_i,
  input  logic [DEN_W-1:0] a_den_i,
  input  logic [NUM_W-1:0] b_num_i,
  input  logic [DEN_W-1:0] b_den_i,
  output logic             push_o,
  output item_t            item_o
);

  logic known, binop;

  always_comb begin
    known = (action_i <= ACT_MIN);
    binop = (action_i <= ACT_CMP) || (action_i == ACT_MAX) || (action_i == ACT_MIN);
    item_o.action  = action_i;
    item_o.a_num   = a_num_i;
    item_o.a_den   = a_den_i;
    item_o.b_num   = b_num_i;
    item_o.b_den   = b_den_i;
    item_o.unknown = !known;
    item_o.den_err = known && ((a_den_i == '0) || (binop && (b_den_i == '0)));
  end

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

endmodule

[rtl/rau_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_back
// Sequencer with shared binary gcd, restoring divider, multiplier and isqrt.
// ----------------------------------------------------------------------------
module rau_back import rau_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  item_t            item_i,
  output logic             pop_o,
  output logic             done_o,
  output logic [NUM_W-1:0] res_num_o,
  output logic [DEN_W-1:0] res_den_o,
  output logic             less_o,
  output logic             equal_o,
  output logic             is_square_o,
  output logic [1:0]       status_o
);

  localparam logic [63:0] LIM     = 64'h7FFF_FFFF;
  localparam logic [31:0] SQ_BIT0 = 32'h4000_0000;

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_RED   = 23'h000002,
    S_GCD   = 23'h000004,
    S_RQ1   = 23'h000008,
    S_RQ2   = 23'h000010,
    S_RQ3   = 23'h000020,
    S_DIV   = 23'h000040,
    S_GOTA  = 23'h000080,
    S_GOTB  = 23'h000100,
    S_AL    = 23'h000200,
    S_AR    = 23'h000400,
    S_AM1   = 23'h000800,
    S_AM2   = 23'h001000,
    S_AM3   = 23'h002000,
    S_ACOMB = 23'h004000,
    S_P1    = 23'h008000,
    S_P2    = 23'h010000,
    S_MD1   = 23'h020000,
    S_MD2   = 23'h040000,
    S_MD3   = 23'h080000,
    S_SQ    = 23'h100000,
    S_CHK   = 23'h200000,
    S_OUT   = 23'h400000
  } state_e;

  function automatic logic [31:0] absmag(input logic [31:0] v);
    absmag = v[31] ? (~v + 32'd1) : v;
  endfunction

  state_e state_q, state_d, ret_q, ret_d, gret_q, gret_d, dret_q, dret_d;
  logic   done_q, done_d;

  item_t       cur_q, cur_d;
  logic        an_q, an_d, bn_q, bn_d, rn_q, rn_d;
  logic [31:0] am_q, am_d, bm_q, bm_d;
  logic [30:0] ad_q, ad_d, bd_q, bd_d;
  logic [63:0] rm_q, rm_d, rd_q, rd_d;
  logic [63:0] gx_q, gx_d, gy_q, gy_d, g_q, g_d;
  logic [6:0]  gk_q, gk_d;
  logic [63:0] dq_q, dq_d, dr_q, dr_d, ds_q, ds_d;
  logic [5:0]  dc_q, dc_d;
  logic [31:0] lf_q, lf_d;
  logic [63:0] t1_q, t1_d, t2_q, t2_d;
  logic [31:0] sx_q, sx_d, sres_q, sres_d, sbit_q, sbit_d, sroot_q, sroot_d;
  logic        sph_q, sph_d, sok_q, sok_d;
  logic        less_q, less_d, eq_q, eq_d, sq_q, sq_d;
  logic [1:0]  st_q, st_d;
  logic [31:0] onum_q, onum_d;
  logic [30:0] oden_q, oden_d;
  logic        oless_q, oless_d, oeq_q, oeq_d, osq_q, osq_d;
  logic [1:0]  ost_q, ost_d;

  logic [31:0] mx, my;
  logic [63:0] mp;
  logic [64:0] dsh, dsub;
  logic        dge;
  logic [31:0] ssum, sx_n, sres_n;
  logic        sge;
  logic        flip, bnf, dneg, dzero;
  logic [63:0] dmag, nlim;

  assign mp = 64'(mx) * 64'(my);

  always_comb begin
    mx = am_q;
    my = bm_q;
    case (state_q)
      S_AM1:   begin mx = am_q;               my = dq_q[31:0]; end
      S_AM2:   begin mx = bm_q;               my = lf_q; end
      S_AM3:   begin mx = {1'b0, ad_q};       my = dq_q[31:0]; end
      S_P1:    begin
        mx = am_q;
        my = (cur_q.action == ACT_DIV) ? {1'b0, bd_q} : bm_q;
      end
      S_P2:    begin
        mx = {1'b0, ad_q};
        my = (cur_q.action == ACT_DIV) ? bm_q : {1'b0, bd_q};
      end
      S_MD1:   begin mx = absmag(cur_q.b_num); my = {1'b0, cur_q.a_den}; end
      default: begin mx = am_q;               my = bm_q; end
    endcase
  end

  always_comb begin
    dsh  = {dr_q, dq_q[63]};
    dge  = (dsh >= {1'b0, ds_q});
    dsub = dsh - {1'b0, ds_q};

    ssum   = sres_q + sbit_q;
    sge    = (sx_q >= ssum);
    sx_n   = sge ? (sx_q - ssum) : sx_q;
    sres_n = sge ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);

    flip = (cur_q.action != ACT_ADD);
    bnf  = flip ^ bn_q;
    if (an_q == bnf) begin
      dmag = t1_q + t2_q;
      dneg = an_q;
    end else if (t1_q >= t2_q) begin
      dmag = t1_q - t2_q;
      dneg = an_q;
    end else begin
      dmag = t2_q - t1_q;
      dneg = bnf;
    end
    dzero = (dmag == '0);
    nlim  = rn_q ? (LIM + 64'd1) : LIM;
  end

  always_comb begin
    state_d = state_q; ret_d = ret_q; gret_d = gret_q; dret_d = dret_q;
    done_d  = 1'b0;
    cur_d = cur_q;
    an_d = an_q; am_d = am_q; ad_d = ad_q;
    bn_d = bn_q; bm_d = bm_q; bd_d = bd_q;
    rn_d = rn_q; rm_d = rm_q; rd_d = rd_q;
    gx_d = gx_q; gy_d = gy_q; gk_d = gk_q; g_d = g_q;
    dq_d = dq_q; dr_d = dr_q; ds_d = ds_q; dc_d = dc_q;
    lf_d = lf_q; t1_d = t1_q; t2_d = t2_q;
    sx_d = sx_q; sres_d = sres_q; sbit_d = sbit_q; sroot_d = sroot_q;
    sph_d = sph_q; sok_d = sok_q;
    less_d = less_q; eq_d = eq_q; sq_d = sq_q; st_d = st_q;
    onum_d = onum_q; oden_d = oden_q; oless_d = oless_q; oeq_d = oeq_q;
    osq_d = osq_q; ost_d = ost_q;
    pop_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          cur_d  = item_i;
          st_d   = ST_OK;
          less_d = 1'b0; eq_d = 1'b0; sq_d = 1'b0;
          rn_d   = 1'b0; rm_d = 64'd0; rd_d = 64'd1;
          if (item_i.den_err) begin
            st_d    = ST_DIVZ;
            state_d = S_OUT;
          end else if (item_i.unknown) begin
            state_d = S_OUT;
          end else begin
            rn_d    = item_i.a_num[31];
            rm_d    = {32'd0, absmag(item_i.a_num)};
            rd_d    = {33'd0, item_i.a_den};
            ret_d   = S_GOTA;
            state_d = S_RED;
          end
        end
      end
      S_RED: begin
        if (rm_q == '0) begin
          rn_d = 1'b0; rd_d = 64'd1;
          state_d = ret_q;
        end else begin
          gx_d = rm_q; gy_d = rd_q; gk_d = '0;
          gret_d  = S_RQ1;
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (gx_q == '0 || gy_q == '0) begin
          g_d     = ((gx_q == '0) ? gy_q : gx_q) << gk_q;
          state_d = gret_q;
        end else if (!gx_q[0] && !gy_q[0]) begin
          gx_d = gx_q >> 1; gy_d = gy_q >> 1; gk_d = gk_q + 7'd1;
        end else if (!gx_q[0]) begin
          gx_d = gx_q >> 1;
        end else if (!gy_q[0]) begin
          gy_d = gy_q >> 1;
        end else if (gx_q >= gy_q) begin
          gx_d = (gx_q - gy_q) >> 1;
        end else begin
          gy_d = (gy_q - gx_q) >> 1;
        end
      end
      S_RQ1: begin
        dq_d = rm_q; dr_d = '0; ds_d = g_q; dc_d = '0;
        dret_d = S_RQ2; state_d = S_DIV;
      end
      S_RQ2: begin
        rm_d = dq_q;
        dq_d = rd_q; dr_d = '0; ds_d = g_q; dc_d = '0;
        dret_d = S_RQ3; state_d = S_DIV;
      end
      S_RQ3: begin
        rd_d    = dq_q;
        state_d = ret_q;
      end
      S_DIV: begin
        dr_d = dge ? dsub[63:0] : dsh[63:0];
        dq_d = {dq_q[62:0], dge};
        dc_d = dc_q + 6'd1;
        if (dc_q == 6'd63) begin
          state_d = dret_q;
        end
      end
      S_GOTA: begin
        an_d = rn_q; am_d = rm_q[31:0]; ad_d = rd_q[30:0];
        rn_d = cur_q.b_num[31];
        rm_d = {32'd0, absmag(cur_q.b_num)};
        rd_d = {33'd0, cur_q.b_den};
        ret_d   = S_GOTB;
        state_d = S_RED;
      end
      S_GOTB: begin
        bn_d = rn_q; bm_d = rm_q[31:0]; bd_d = rd_q[30:0];
        case (cur_q.action)
          ACT_ADD, ACT_SUB, ACT_CMP, ACT_MAX, ACT_MIN: begin
            gx_d = {33'd0, ad_q}; gy_d = rd_q; gk_d = '0;
            gret_d = S_AL; state_d = S_GCD;
          end
          ACT_MUL: state_d = S_P1;
          ACT_DIV: begin
            if (rm_q == '0) begin
              st_d = ST_DIVZ;
              rn_d = 1'b0; rm_d = 64'd0; rd_d = 64'd1;
              state_d = S_OUT;
            end else begin
              state_d = S_P1;
            end
          end
          ACT_MOD: state_d = S_MD1;
          ACT_NEG: begin
            rn_d = !an_q && (am_q != '0);
            rm_d = {32'd0, am_q}; rd_d = {33'd0, ad_q};
            state_d = S_CHK;
          end
          ACT_ABS: begin
            rn_d = 1'b0;
            rm_d = {32'd0, am_q}; rd_d = {33'd0, ad_q};
            state_d = S_CHK;
          end
          ACT_SIGN: begin
            rn_d = an_q;
            rm_d = {63'd0, (am_q != '0)}; rd_d = 64'd1;
            state_d = S_CHK;
          end
          ACT_SQRT: begin
            rn_d = 1'b0; rm_d = 64'd0; rd_d = 64'd1;
            if (am_q == '0) begin
              sq_d = 1'b1;
              state_d = S_CHK;
            end else if (an_q) begin
              state_d = S_CHK;
            end else begin
              sx_d = am_q; sres_d = '0; sbit_d = SQ_BIT0; sph_d = 1'b0;
              state_d = S_SQ;
            end
          end
          default: begin
            rn_d = 1'b0; rm_d = 64'd0; rd_d = 64'd1;
            state_d = S_OUT;
          end
        endcase
      end
      S_AL: begin
        dq_d = {33'd0, ad_q}; dr_d = '0; ds_d = g_q; dc_d = '0;
        dret_d = S_AR; state_d = S_DIV;
      end
      S_AR: begin
        lf_d = dq_q[31:0];
        dq_d = {33'd0, bd_q}; dr_d = '0; ds_d = g_q; dc_d = '0;
        dret_d = S_AM1; state_d = S_DIV;
      end
      S_AM1: begin
        t1_d = mp; state_d = S_AM2;
      end
      S_AM2: begin
        t2_d = mp; state_d = S_AM3;
      end
      S_AM3: begin
        rd_d = mp; state_d = S_ACOMB;
      end
      S_ACOMB: begin
        case (cur_q.action)
          ACT_ADD, ACT_SUB: begin
            rn_d = dneg; rm_d = dmag;
            ret_d = S_CHK; state_d = S_RED;
          end
          ACT_CMP: begin
            less_d = !dzero && dneg;
            eq_d   = dzero;
            rn_d = 1'b0; rm_d = 64'd0; rd_d = 64'd1;
            state_d = S_CHK;
          end
          ACT_MAX: begin
            if (!dzero && !dneg) begin
              rn_d = an_q; rm_d = {32'd0, am_q}; rd_d = {33'd0, ad_q};
            end else begin
              rn_d = bn_q; rm_d = {32'd0, bm_q}; rd_d = {33'd0, bd_q};
            end
            state_d = S_CHK;
          end
          default: begin
            if (!dzero && dneg) begin
              rn_d = an_q; rm_d = {32'd0, am_q}; rd_d = {33'd0, ad_q};
            end else begin
              rn_d = bn_q; rm_d = {32'd0, bm_q}; rd_d = {33'd0, bd_q};
            end
            state_d = S_CHK;
          end
        endcase
      end
      S_P1: begin
        rm_d = mp; state_d = S_P2;
      end
      S_P2: begin
        rd_d = mp; rn_d = an_q ^ bn_q;
        ret_d = S_CHK; state_d = S_RED;
      end
      S_MD1: begin
        t1_d = mp; state_d = S_MD2;
      end
      S_MD2: begin
        if (t1_q == '0) begin
          st_d = ST_DIVZ;
          rn_d = 1'b0; rm_d = 64'd0; rd_d = 64'd1;
          state_d = S_OUT;
        end else begin
          dq_d = {32'd0, absmag(cur_q.a_num)}; dr_d = '0; ds_d = t1_q; dc_d = '0;
          dret_d = S_MD3; state_d = S_DIV;
        end
      end
      S_MD3: begin
        rm_d = dr_q; rd_d = {33'd0, cur_q.a_den}; rn_d = cur_q.a_num[31];
        ret_d = S_CHK; state_d = S_RED;
      end
      S_SQ: begin
        sx_d   = sx_n;
        sres_d = sres_n;
        sbit_d = sbit_q >> 2;
        if (sbit_q == 32'd1) begin
          if (!sph_q) begin
            sroot_d = sres_n; sok_d = (sx_n == '0);
            sph_d = 1'b1;
            sx_d = {1'b0, ad_q}; sres_d = '0; sbit_d = SQ_BIT0;
          end else begin
            if (sok_q && (sx_n == '0)) begin
              sq_d = 1'b1;
              rn_d = 1'b0; rm_d = {32'd0, sroot_q}; rd_d = {32'd0, sres_n};
            end
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (rm_q > nlim || rd_q > LIM) begin
          st_d = ST_OVF;
          rn_d = 1'b0; rm_d = 64'd0; rd_d = 64'd1;
          less_d = 1'b0; eq_d = 1'b0; sq_d = 1'b0;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        onum_d  = rn_q ? (32'd0 - rm_q[31:0]) : rm_q[31:0];
        oden_d  = rd_q[30:0];
        oless_d = less_q;
        oeq_d   = eq_q;
        osq_d   = sq_q;
        ost_d   = st_q;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      gret_q  <= S_IDLE;
      dret_q  <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      gret_q  <= gret_d;
      dret_q  <= dret_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    an_q <= an_d; am_q <= am_d; ad_q <= ad_d;
    bn_q <= bn_d; bm_q <= bm_d; bd_q <= bd_d;
    rn_q <= rn_d; rm_q <= rm_d; rd_q <= rd_d;
    gx_q <= gx_d; gy_q <= gy_d; gk_q <= gk_d; g_q <= g_d;
    dq_q <= dq_d; dr_q <= dr_d; ds_q <= ds_d; dc_q <= dc_d;
    lf_q <= lf_d; t1_q <= t1_d; t2_q <= t2_d;
    sx_q <= sx_d; sres_q <= sres_d; sbit_q <= sbit_d; sroot_q <= sroot_d;
    sph_q <= sph_d; sok_q <= sok_d;
    less_q <= less_d; eq_q <= eq_d; sq_q <= sq_d; st_q <= st_d;
    onum_q <= onum_d; oden_q <= oden_d; oless_q <= oless_d; oeq_q <= oeq_d;
    osq_q <= osq_d; ost_q <= ost_d;
  end

  assign done_o      = done_q;
  assign res_num_o   = onum_q;
  assign res_den_o   = oden_q;
  assign less_o      = oless_q;
  assign equal_o     = oeq_q;
  assign is_square_o = osq_q;
  assign status_o    = ost_q;

endmodule
